// File: src/rochp_pkg.sv
// Package for the ray versus oriented-box closest-hit picker.
// Widths, register map, controller states and control/status structs.
// No dependencies.
package rochp_pkg;

  localparam int VEC_W     = 63;
  localparam int C_W       = 21;
  localparam int FRAC      = 10;
  localparam int DFRAC     = 14;
  localparam int DLT_W     = C_W + 1;
  localparam int P_W       = C_W + DLT_W;
  localparam int ACC_W     = 48;
  localparam int DVD_W     = ACC_W + DFRAC;
  localparam int REM_W     = ACC_W + 1;
  localparam int T_W       = DVD_W + 2;
  localparam int EPS_W     = 20;
  localparam int DIST_W    = 32;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 12;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam int DIV_STEPS = DVD_W;

  localparam logic [1:0] REG_ORIGIN = 2'd0;
  localparam logic [1:0] REG_DIR    = 2'd1;
  localparam logic [1:0] REG_EPS    = 2'd2;
  localparam logic [1:0] REG_FAR    = 2'd3;

  localparam logic [EPS_W-1:0]  EPS_RESET = 20'd1;
  localparam logic [DIST_W-1:0] FAR_RESET = 32'd1638400000;

  localparam logic [1:0] LAST_AXIS = 2'd2;
  localparam logic [2:0] LAST_MUL  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_TEST, S_DIV, S_DIVEND, S_CHK, S_UPD, S_OUT
  } state_t;

  typedef struct packed {
    logic [VEC_W-1:0]  origin;
    logic [VEC_W-1:0]  dir;
    logic [EPS_W-1:0]  eps;
    logic [DIST_W-1:0] far_lim;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       clr_acc;
    logic       mul;
    logic       add;
    logic       div_start;
    logic       num_sel;
    logic       div_step;
    logic       save_t1;
    logic       slab;
    logic       upd;
    logic       emit;
    logic [1:0] ai;
    logic [2:0] mi;
  } cmd_t;

  typedef struct packed {
    logic sel;
    logic last;
    logic parallel;
    logic par_miss;
    logic slab_miss;
    logic out_busy;
  } status_t;

  function automatic logic signed [C_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                 input logic [1:0] k);
    comp = v[k*C_W +: C_W];
  endfunction

endpackage

// File: src/rochp_in_if.sv
// Box input channel: valid/ready plus one box description.
// Depends on rochp_pkg.
interface rochp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rochp_pkg::VEC_W-1:0]  axis_x;
  logic [rochp_pkg::VEC_W-1:0]  axis_y;
  logic [rochp_pkg::VEC_W-1:0]  axis_z;
  logic [rochp_pkg::VEC_W-1:0]  box_position;
  logic [rochp_pkg::VEC_W-1:0]  box_min;
  logic [rochp_pkg::VEC_W-1:0]  box_max;
  logic [rochp_pkg::KIND_W-1:0] object_kind;
  logic [rochp_pkg::IDX_W-1:0]  object_index;
  logic                       selectable;
  logic                       last_object;

  modport source (output valid, axis_x, axis_y, axis_z, box_position, box_min,
                  box_max, object_kind, object_index, selectable, last_object,
                  input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, box_position, box_min,
                box_max, object_kind, object_index, selectable, last_object,
                output ready);
endinterface

// File: src/rochp_out_if.sv
// Result channel: valid/ready plus the nearest-hit report.
// Depends on rochp_pkg.
interface rochp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [rochp_pkg::KIND_W-1:0] hit_kind;
  logic [rochp_pkg::IDX_W-1:0]  hit_index;
  logic [rochp_pkg::DIST_W-1:0] hit_distance;

  modport source (output valid, hit, hit_kind, hit_index, hit_distance,
                  input ready);
  modport sink (input valid, hit, hit_kind, hit_index, hit_distance,
                output ready);
endinterface

// File: src/rochp_regs.sv
// APB configuration registers: ray origin, direction, epsilon, far limit.
// Depends on rochp_pkg.
module rochp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rochp_pkg::ADDR_W-1:0] paddr,
  input  logic [rochp_pkg::DATA_W-1:0] pwdata,
  output logic [rochp_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output rochp_pkg::cfg_t              cfg
);
  import rochp_pkg::*;

  logic [1:0] ridx;
  logic       wr;

  assign ridx   = paddr[ADDR_W-1:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin  <= '0;
      cfg.dir     <= '0;
      cfg.eps     <= EPS_RESET;
      cfg.far_lim <= FAR_RESET;
    end else if (wr) begin
      case (ridx)
        REG_ORIGIN: cfg.origin  <= pwdata[VEC_W-1:0];
        REG_DIR:    cfg.dir     <= pwdata[VEC_W-1:0];
        REG_EPS:    cfg.eps     <= pwdata[EPS_W-1:0];
        REG_FAR:    cfg.far_lim <= pwdata[DIST_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORIGIN: prdata = DATA_W'(cfg.origin);
      REG_DIR:    prdata = DATA_W'(cfg.dir);
      REG_EPS:    prdata = DATA_W'(cfg.eps);
      REG_FAR:    prdata = DATA_W'(cfg.far_lim);
      default:    prdata = '0;
    endcase
  end
endmodule

// File: src/rochp_ctrl.sv
// Controller: sequences multiply, divide and slab steps for one box.
// Depends on rochp_pkg.
module rochp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rochp_pkg::status_t st,
  output rochp_pkg::cmd_t    cmd
);
  import rochp_pkg::*;

  state_t           state, state_next;
  logic [1:0]       ai;
  logic [2:0]       mi;
  logic [CNT_W-1:0] cnt;
  logic             div_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ai      <= '0;
      mi      <= '0;
      cnt     <= '0;
      div_sel <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          ai <= '0;
          mi <= '0;
        end
        S_ADD: mi <= mi + 3'd1;
        S_TEST: begin
          cnt     <= '0;
          div_sel <= 1'b0;
          if (st.parallel && !st.par_miss && ai != LAST_AXIS) begin
            ai <= ai + 2'd1;
            mi <= '0;
          end
        end
        S_DIV: cnt <= cnt + CNT_W'(1);
        S_DIVEND: begin
          cnt     <= '0;
          div_sel <= 1'b1;
        end
        S_CHK: begin
          if (!st.slab_miss && ai != LAST_AXIS) begin
            ai <= ai + 2'd1;
            mi <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL;
      S_MUL:    state_next = st.sel ? S_ADD : S_OUT;
      S_ADD:    state_next = (mi == LAST_MUL) ? S_TEST : S_MUL;
      S_TEST: begin
        if (!st.parallel)     state_next = S_DIV;
        else if (st.par_miss) state_next = S_OUT;
        else                  state_next = (ai == LAST_AXIS) ? S_UPD : S_MUL;
      end
      S_DIV:    if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_DIVEND;
      S_DIVEND: state_next = div_sel ? S_CHK : S_DIV;
      S_CHK: begin
        if (st.slab_miss) state_next = S_OUT;
        else              state_next = (ai == LAST_AXIS) ? S_UPD : S_MUL;
      end
      S_UPD:    state_next = S_OUT;
      S_OUT:    if (!st.last || !st.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ai   = ai;
    cmd.mi   = mi;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL: cmd.mul = 1'b1;
      S_ADD: cmd.add = 1'b1;
      S_TEST: begin
        if (!st.parallel) begin
          cmd.div_start = 1'b1;
        end else if (!st.par_miss && ai != LAST_AXIS) begin
          cmd.clr_acc = 1'b1;
        end
      end
      S_DIV: cmd.div_step = 1'b1;
      S_DIVEND: begin
        if (!div_sel) begin
          cmd.save_t1   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.num_sel   = 1'b1;
        end else begin
          cmd.slab = 1'b1;
        end
      end
      S_CHK: if (!st.slab_miss && ai != LAST_AXIS) cmd.clr_acc = 1'b1;
      S_UPD: cmd.upd = 1'b1;
      S_OUT: cmd.emit = st.last && !st.out_busy;
      default: ;
    endcase
  end
endmodule

// File: src/rochp_dp.sv
// Datapath: box registers, shared multiplier, bit-serial divider,
// slab bounds, nearest-hit state and result register. Depends on rochp_pkg.
module rochp_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rochp_pkg::cfg_t              cfg,
  input  rochp_pkg::cmd_t              cmd,
  output rochp_pkg::status_t           st,
  input  logic [rochp_pkg::VEC_W-1:0]  axis_x,
  input  logic [rochp_pkg::VEC_W-1:0]  axis_y,
  input  logic [rochp_pkg::VEC_W-1:0]  axis_z,
  input  logic [rochp_pkg::VEC_W-1:0]  box_position,
  input  logic [rochp_pkg::VEC_W-1:0]  box_min,
  input  logic [rochp_pkg::VEC_W-1:0]  box_max,
  input  logic [rochp_pkg::KIND_W-1:0] object_kind,
  input  logic [rochp_pkg::IDX_W-1:0]  object_index,
  input  logic                         selectable,
  input  logic                         last_object,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [rochp_pkg::KIND_W-1:0] hit_kind,
  output logic [rochp_pkg::IDX_W-1:0]  hit_index,
  output logic [rochp_pkg::DIST_W-1:0] hit_distance
);
  import rochp_pkg::*;

  logic [VEC_W-1:0]        ax [3];
  logic [VEC_W-1:0]        bmin, bmax;
  logic signed [DLT_W-1:0] delta [3];
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        idx;
  logic                    sel, last;

  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc_e, acc_f;
  logic [DVD_W-1:0]        dvd, quo;
  logic [REM_W-1:0]        rem;
  logic [ACC_W-1:0]        dvs;
  logic                    neg;
  logic signed [T_W-1:0]   t1, tmin, tmax;

  logic                    any_hit;
  logic [DIST_W-1:0]       near_d;
  logic [KIND_W-1:0]       near_k;
  logic [IDX_W-1:0]        near_i;

  logic [1:0]              k;
  logic signed [C_W-1:0]   mul_a;
  logic signed [DLT_W-1:0] mul_b;
  logic signed [ACC_W-1:0] lo, hi, num;
  logic [ACC_W-1:0]        num_mag, f_mag;
  logic [REM_W-1:0]        rtry;
  logic signed [T_W-1:0]   tq, lo_t, hi_t;
  logic [DIST_W-1:0]       cand_d;

  assign k     = (cmd.mi < 3'd3) ? cmd.mi[1:0] : 2'(cmd.mi - 3'd3);
  assign mul_a = comp(ax[cmd.ai], k);
  assign mul_b = (cmd.mi < 3'd3) ? delta[k] : DLT_W'(comp(cfg.dir, k));

  assign lo      = ACC_W'(signed'({comp(bmin, cmd.ai), FRAC'(0)}));
  assign hi      = ACC_W'(signed'({comp(bmax, cmd.ai), FRAC'(0)}));
  assign num     = cmd.num_sel ? acc_e + hi : acc_e + lo;
  assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign f_mag   = acc_f[ACC_W-1] ? ACC_W'(-acc_f) : ACC_W'(acc_f);
  assign rtry    = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign tq      = neg ? -signed'(T_W'(quo)) : signed'(T_W'(quo));
  assign lo_t    = (t1 < tq) ? t1 : tq;
  assign hi_t    = (t1 < tq) ? tq : t1;
  assign cand_d  = tmin[DIST_W-1:0];

  assign st.sel       = sel;
  assign st.last      = last;
  assign st.parallel  = !(f_mag > ACC_W'({cfg.eps, FRAC'(0)}));
  assign st.par_miss  = (lo > acc_e) || (hi < acc_e);
  assign st.slab_miss = tmin > tmax;
  assign st.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax[0] <= axis_x;
      ax[1] <= axis_y;
      ax[2] <= axis_z;
      bmin  <= box_min;
      bmax  <= box_max;
      kind  <= object_kind;
      idx   <= object_index;
      sel   <= selectable;
      last  <= last_object;
      for (int i = 0; i < 3; i++) begin
        delta[i] <= DLT_W'(comp(box_position, 2'(i))) - DLT_W'(comp(cfg.origin, 2'(i)));
      end
      tmin <= '0;
      tmax <= T_W'(cfg.far_lim);
    end else if (cmd.slab) begin
      if (lo_t > tmin) tmin <= lo_t;
      if (hi_t < tmax) tmax <= hi_t;
    end
    if (cmd.mul) prod <= mul_a * mul_b;
    if (cmd.load || cmd.clr_acc) begin
      acc_e <= '0;
      acc_f <= '0;
    end else if (cmd.add) begin
      if (cmd.mi < 3'd3) acc_e <= acc_e + ACC_W'(prod);
      else               acc_f <= acc_f + ACC_W'(prod);
    end
    if (cmd.save_t1) t1 <= tq;
    if (cmd.div_start) begin
      dvd <= {num_mag, DFRAC'(0)};
      dvs <= f_mag;
      rem <= '0;
      quo <= '0;
      neg <= num[ACC_W-1] ^ acc_f[ACC_W-1];
    end else if (cmd.div_step) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (rtry >= REM_W'(dvs)) begin
        rem <= rtry - REM_W'(dvs);
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rtry;
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit   <= 1'b0;
      near_d    <= '1;
      near_k    <= '0;
      near_i    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.upd && (!any_hit || cand_d < near_d)) begin
        any_hit <= 1'b1;
        near_d  <= cand_d;
        near_k  <= kind;
        near_i  <= idx;
      end
      if (cmd.emit) begin
        out_valid    <= 1'b1;
        hit          <= any_hit;
        hit_kind     <= near_k;
        hit_index    <= near_i;
        hit_distance <= near_d;
        any_hit      <= 1'b0;
        near_d       <= '1;
        near_k       <= '0;
        near_i       <= '0;
      end
    end
  end
endmodule

// File: src/ray_obb_closest_hit_picker_top.sv
// Ray versus oriented-box closest-hit picker, top level.
// Boxes arrive on in_ch, one per transfer; the ray, parallel epsilon and
// far limit are set over the APB port (64-bit data, register i at 8*i);
// the user must set them only while the block is idle; the block does not enforce it.
// Each selectable box is slab-tested on its three axes and the nearest hit
// is kept; an equal distance keeps the earlier box. A box flagged
// last_object produces one transfer on out_ch (hit, kind, index, Q18.14
// distance, all ones when nothing was hit) and clears the running state.
// One box at a time: a new box is taken only in the idle state. A box
// skips the divider on an axis that is parallel, and an unselectable box skips the tests.
// The bit-serial divider does most of the work: 62 steps per quotient, two quotients
// per axis that is not parallel, plus multiply and add steps on the shared multiplier per axis.
// The result register lets the next box be taken while a result waits;
// a last box that finishes while out_ch is still stalled waits for it.
// Reset (synchronous, rst high) restores register defaults, clears the
// nearest-hit state and drops out_ch.valid.
// Depends on rochp_pkg, rochp_in_if, rochp_out_if, rochp_regs, rochp_ctrl,
// rochp_dp.
module ray_obb_closest_hit_picker_top (
  input  logic                         clk,
  input  logic                         rst,
  rochp_in_if.sink                     in_ch,
  rochp_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rochp_pkg::ADDR_W-1:0] paddr,
  input  logic [rochp_pkg::DATA_W-1:0] pwdata,
  output logic [rochp_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import rochp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  rochp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  rochp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st, .cmd
  );

  rochp_dp u_dp (
    .clk, .rst, .cfg, .cmd, .st,
    .axis_x       (in_ch.axis_x),
    .axis_y       (in_ch.axis_y),
    .axis_z       (in_ch.axis_z),
    .box_position (in_ch.box_position),
    .box_min      (in_ch.box_min),
    .box_max      (in_ch.box_max),
    .object_kind  (in_ch.object_kind),
    .object_index (in_ch.object_index),
    .selectable   (in_ch.selectable),
    .last_object  (in_ch.last_object),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .hit          (out_ch.hit),
    .hit_kind     (out_ch.hit_kind),
    .hit_index    (out_ch.hit_index),
    .hit_distance (out_ch.hit_distance)
  );
endmodule

// File: sim/ray_obb_closest_hit_picker_top_test.sv
// Self-checking testbench for ray_obb_closest_hit_picker_top: configures the
// ray over APB, streams box queries and checks each nearest-hit report.
// Depends on rochp_pkg, rochp_in_if, rochp_out_if and the RTL under src.
module ray_obb_closest_hit_picker_top_test;
  import rochp_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int SETTLE       = 600;

  typedef struct {
    logic [VEC_W-1:0]  ax, ay, az, pos, bmin, bmax;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              sel, last;
  } box_t;

  typedef struct {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } pick_t;

  class pick_scoreboard;
    logic [VEC_W-1:0]  origin, dir;
    logic [EPS_W-1:0]  eps;
    logic [DIST_W-1:0] far_lim;
    logic [DIST_W-1:0] best_dist;
    logic [KIND_W-1:0] best_kind;
    logic [IDX_W-1:0]  best_idx;
    logic              any;
    pick_t             picks_due[$];
    int                errors, checked, hits;

    function new();
      origin = '0; dir = '0; eps = EPS_RESET; far_lim = FAR_RESET;
      errors = 0; checked = 0; hits = 0;
      clear();
    endfunction

    function void clear();
      best_dist = '1; best_kind = '0; best_idx = '0; any = 1'b0;
    endfunction

    function void set_reg(logic [1:0] r, logic [63:0] v);
      case (r)
        REG_ORIGIN: origin = v[VEC_W-1:0];
        REG_DIR:    dir = v[VEC_W-1:0];
        REG_EPS:    eps = v[EPS_W-1:0];
        REG_FAR:    far_lim = v[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function longint cval(logic [VEC_W-1:0] v, int k);
      logic signed [C_W-1:0] c;
      c = v[k*C_W +: C_W];
      return longint'(c);
    endfunction

    function longint quot(longint num, longint den);
      logic [63:0] n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n << DFRAC) / d;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function logic slab_hit(box_t b, output logic [DIST_W-1:0] t_entry);
      longint dl[3], dr[3], tmin, tmax, thr, e, f, lo, hi, t1, t2, w;
      logic [VEC_W-1:0] axv[3];
      axv[0] = b.ax; axv[1] = b.ay; axv[2] = b.az;
      tmin = 0; tmax = longint'(far_lim); thr = longint'(eps) * 1024;
      t_entry = '0;
      for (int a = 0; a < 3; a++) begin
        dl[a] = cval(b.pos, a) - cval(origin, a);
        dr[a] = cval(dir, a);
      end
      for (int a = 0; a < 3; a++) begin
        e = 0; f = 0;
        for (int k = 0; k < 3; k++) begin
          e += cval(axv[a], k) * dl[k];
          f += cval(axv[a], k) * dr[k];
        end
        lo = cval(b.bmin, a) * 1024;
        hi = cval(b.bmax, a) * 1024;
        if ((f < 0 ? -f : f) > thr) begin
          t1 = quot(e + lo, f);
          t2 = quot(e + hi, f);
          if (t1 > t2) begin w = t1; t1 = t2; t2 = w; end
          if (t1 > tmin) tmin = t1;
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax) return 1'b0;
        end else if (lo - e > 0 || hi - e < 0) begin
          return 1'b0;
        end
      end
      t_entry = tmin[DIST_W-1:0];
      return 1'b1;
    endfunction

    function void note_box(box_t b);
      logic [DIST_W-1:0] d;
      pick_t p;
      if (b.sel && slab_hit(b, d)) begin
        if (!any || d < best_dist) begin
          best_dist = d; best_kind = b.kind; best_idx = b.idx; any = 1'b1;
        end
      end
      if (b.last) begin
        p.hit = any;
        p.kind = any ? best_kind : '0;
        p.idx = any ? best_idx : '0;
        p.distance = any ? best_dist : '1;
        picks_due = {picks_due, p};
        clear();
      end
    endfunction

    function void check_pick(pick_t got);
      pick_t exp_p;
      checked++;
      if (got.hit) hits++;
      if (picks_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: hit=%0b idx=%0d", got.hit,
                                   got.idx);
        return;
      end
      exp_p = picks_due.pop_front();
      if (got.hit !== exp_p.hit || got.kind !== exp_p.kind || got.idx !== exp_p.idx ||
          got.distance !== exp_p.distance) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%0b kind=%0d idx=%0d dist=%h, got %0b %0d %0d %h",
                   exp_p.hit, exp_p.kind, exp_p.idx, exp_p.distance,
                   got.hit, got.kind, got.idx, got.distance);
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  rochp_in_if  in_ch();
  rochp_out_if out_ch();

  ray_obb_closest_hit_picker_top i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pick_scoreboard sb = new();
  int cycles = 0;
  int boxes_sent = 0;
  logic holding = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("ray_obb_closest_hit_picker_top_test: FAIL");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    pick_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.hit = out_ch.hit; got.kind = out_ch.hit_kind;
      got.idx = out_ch.hit_index; got.distance = out_ch.hit_distance;
      sb.check_pick(got);
    end
    if (rst || holding) out_ch.ready <= 1'b0;
    else if (cycles > 20000 && cycles < 60000) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 32);
  end

  // long hold-off on the result side
  initial begin
    wait (boxes_sent >= 200);
    @(posedge clk) holding <= 1'b1;
    repeat (4000) @(posedge clk);
    holding <= 1'b0;
  end

  function automatic logic [VEC_W-1:0] pack3(int x, int y, int z);
    logic [C_W-1:0] a, b, c;
    a = C_W'(x); b = C_W'(y); c = C_W'(z);
    return {c, b, a};
  endfunction

  function automatic logic [VEC_W-1:0] rnd_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  task automatic reg_write(logic [1:0] r, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(r, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_box(box_t b);
    int gap;
    gap = 0;
    if (!(boxes_sent >= 700 && boxes_sent < 900) && $urandom_range(99) < 32)
      gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.axis_x <= b.ax; in_ch.axis_y <= b.ay; in_ch.axis_z <= b.az;
    in_ch.box_position <= b.pos; in_ch.box_min <= b.bmin; in_ch.box_max <= b.bmax;
    in_ch.object_kind <= b.kind; in_ch.object_index <= b.idx;
    in_ch.selectable <= b.sel; in_ch.last_object <= b.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_box(b);
    boxes_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic box_t unit_box(int px, int py, int pz, int h, logic last);
    box_t b;
    b.ax = pack3(1024, 0, 0); b.ay = pack3(0, 1024, 0); b.az = pack3(0, 0, 1024);
    b.pos = pack3(px, py, pz);
    b.bmin = pack3(-h, -h, -h); b.bmax = pack3(h, h, h);
    b.kind = KIND_W'($urandom_range(3)); b.idx = IDX_W'($urandom_range(4095));
    b.sel = 1'b1; b.last = last;
    return b;
  endfunction

  // mostly well-formed boxes placed near the ray; some raw noise
  function automatic box_t rand_box(logic last);
    box_t b;
    int s, sg[3], h;
    if ($urandom_range(99) < 15) begin
      b.ax = rnd_vec(); b.ay = rnd_vec(); b.az = rnd_vec();
      b.pos = rnd_vec(); b.bmin = rnd_vec(); b.bmax = rnd_vec();
    end else begin
      for (int k = 0; k < 3; k++) sg[k] = $urandom_range(1) ? 1024 : -1024;
      if ($urandom_range(1)) begin
        b.ax = pack3(sg[0], 0, 0); b.ay = pack3(0, sg[1], 0); b.az = pack3(0, 0, sg[2]);
      end else begin
        b.ax = pack3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                     $urandom_range(2048) - 1024);
        b.ay = pack3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                     $urandom_range(2048) - 1024);
        b.az = pack3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                     $urandom_range(2048) - 1024);
      end
      s = $urandom_range(64);
      b.pos = pack3(int'(sb.cval(sb.origin, 0) + sb.cval(sb.dir, 0) * s / 8) +
                    $urandom_range(4096) - 2048,
                    int'(sb.cval(sb.origin, 1) + sb.cval(sb.dir, 1) * s / 8) +
                    $urandom_range(4096) - 2048,
                    int'(sb.cval(sb.origin, 2) + sb.cval(sb.dir, 2) * s / 8) +
                    $urandom_range(4096) - 2048);
      h = $urandom_range(8192);
      b.bmin = pack3(-$urandom_range(h), -$urandom_range(h), -$urandom_range(h));
      b.bmax = pack3($urandom_range(h), $urandom_range(h), $urandom_range(h));
    end
    b.kind = KIND_W'($urandom_range(3));
    b.idx = IDX_W'($urandom_range(4095));
    b.sel = ($urandom_range(99) < 80);
    b.last = last;
    return b;
  endfunction

  task automatic random_queries(int n);
    int left, qlen;
    left = n;
    while (left > 0) begin
      qlen = $urandom_range(1, 6);
      for (int i = 0; i < qlen; i++) send_box(rand_box(i == qlen - 1));
      left -= qlen;
    end
    drain();
  endtask

  task automatic directed();
    box_t b;
    send_box(unit_box(10240, 0, 0, 1024, 1'b1));
    b = unit_box(10240, 0, 0, 1024, 1'b0); b.sel = 1'b0; send_box(b);
    send_box(unit_box(20480, 0, 0, 1024, 1'b1));
    send_box(unit_box(0, 20480, 0, 1024, 1'b1));
    send_box(unit_box(5120, 0, 0, 512, 1'b0));
    send_box(unit_box(5120, 0, 0, 512, 1'b1));
    send_box(unit_box(30720, 0, 0, 1024, 1'b0));
    send_box(unit_box(8192, 0, 0, 1024, 1'b1));
    send_box(unit_box(0, 0, 0, 2048, 1'b1));
    send_box(unit_box(-10240, 0, 0, 1024, 1'b1));
    b = unit_box(0, 0, 0, 0, 1'b1);
    b.ax = '1; b.ay = '1; b.az = '1; b.pos = '1; b.bmin = '1; b.bmax = '1;
    b.kind = '1; b.idx = '1; send_box(b);
    b.ax = '0; b.ay = '0; b.az = '0; b.pos = '0; b.bmin = '0; b.bmax = '0;
    b.kind = '0; b.idx = '0; send_box(b);
    b = unit_box(10240, 0, 0, 1024, 1'b1); b.sel = 1'b0; send_box(b);
    drain();
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.axis_x = '0; in_ch.axis_y = '0; in_ch.axis_z = '0;
    in_ch.box_position = '0; in_ch.box_min = '0; in_ch.box_max = '0;
    in_ch.object_kind = '0; in_ch.object_index = '0;
    in_ch.selectable = 1'b0; in_ch.last_object = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default registers: zero direction, every axis parallel
    random_queries(40);

    reg_write(REG_ORIGIN, 64'(pack3(0, 0, 0)));
    reg_write(REG_DIR, 64'(pack3(1024, 0, 0)));
    directed();
    random_queries(260);

    reg_write(REG_EPS, '0);
    reg_write(REG_FAR, 64'hFFFF_FFFF);
    reg_write(REG_ORIGIN, 64'(pack3($urandom_range(8192) - 4096, $urandom_range(8192) - 4096,
                                    $urandom_range(8192) - 4096)));
    reg_write(REG_DIR, 64'(pack3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                                 $urandom_range(2048) - 1024)));
    random_queries(300);

    reg_write(REG_EPS, 64'hF_FFFF);
    reg_write(REG_FAR, '0);
    random_queries(150);

    reg_write(REG_ORIGIN, {$urandom, $urandom});
    reg_write(REG_DIR, {$urandom, $urandom});
    reg_write(REG_EPS, 64'($urandom_range(1048575)));
    reg_write(REG_FAR, 64'($urandom));
    random_queries(150);

    reg_write(REG_ORIGIN, 64'(pack3(0, 0, 40960)));
    reg_write(REG_DIR, 64'(pack3(0, 0, -1024)));
    reg_write(REG_EPS, 64'd100);
    reg_write(REG_FAR, 64'd1638400000);
    random_queries(300);

    reg_write(REG_EPS, 64'd1);
    reg_write(REG_FAR, 64'd16384 * 20);
    random_queries(300);

    $display("sent %0d boxes over 7 register settings, checked %0d reports (%0d hits)",
             boxes_sent, sb.checked, sb.hits);
    if (sb.errors == 0 && sb.picks_due.size() == 0)
      $display("ray_obb_closest_hit_picker_top_test: PASS");
    else begin
      $display("%0d mismatches, %0d reports missing", sb.errors, sb.picks_due.size());
      $display("ray_obb_closest_hit_picker_top_test: FAIL");
    end
    $finish;
  end
endmodule
